[rtl/nqj_pkg.sv]
// Shared types, constants and helpers for the normalized quaternion Jacobian.
// No dependencies; every module of the block imports this package.
package nqj_pkg;

  localparam int unsigned IN_W                 = 16;
  localparam int unsigned OUT_WIDTH            = 24;
  localparam int unsigned IN_FRACTION_BITS_DEF = 14;
  localparam int unsigned SQRT_EXTRA           = 15;
  localparam int unsigned OUT_FRACTION_BITS    = 16;
  localparam int unsigned SQ_W                 = 31;  // one squared component
  localparam int unsigned PR_W                 = 32;  // signed product of two components
  localparam int unsigned S_W                  = 33;  // sum of four squares
  localparam int unsigned N_W                  = 35;  // signed numerator entry
  localparam int unsigned MAG_W                = 33;  // numerator magnitude
  localparam int unsigned R_W                  = 32;  // square root result
  localparam int unsigned X_W                  = 64;  // square root operand
  localparam int unsigned D_W                  = 64;  // denominator S * R
  localparam int unsigned SQ_STEPS             = 32;  // root bits, one per stage
  localparam int unsigned NUM_COLS             = 4;

  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef struct packed {
    logic signed [IN_W-1:0] q_w;
    logic signed [IN_W-1:0] q_x;
    logic signed [IN_W-1:0] q_y;
    logic signed [IN_W-1:0] q_z;
  } nqj_in_t;

  typedef struct packed {
    logic [1:0]                  row_index;
    logic signed [OUT_WIDTH-1:0] entry_col0;
    logic signed [OUT_WIDTH-1:0] entry_col1;
    logic signed [OUT_WIDTH-1:0] entry_col2;
    logic signed [OUT_WIDTH-1:0] entry_col3;
    logic                        zero_norm;
    logic                        saturated;
    logic                        last_row;
  } nqj_out_t;

  // Row context that rides along the square root pipeline.
  typedef struct packed {
    logic [1:0]                   row;
    logic                         zero;
    logic [S_W-1:0]               s;
    logic [NUM_COLS-1:0][N_W-1:0] n;
  } nqj_sq_ctx_t;

  // Row context that rides along the divider pipeline.
  typedef struct packed {
    logic [1:0]          row;
    logic                zero;
    logic [NUM_COLS-1:0] neg;
  } nqj_div_ctx_t;

  function automatic logic signed [IN_W-1:0] nqj_comp(nqj_in_t q, logic [1:0] idx);
    logic signed [IN_W-1:0] c;
    case (idx)
      2'd0:    c = q.q_w;
      2'd1:    c = q.q_x;
      2'd2:    c = q.q_y;
      default: c = q.q_z;
    endcase
    return c;
  endfunction

endpackage

[rtl/nqj_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on nqj_pkg for widths and the row context type.
module nqj_sqrt import nqj_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic [X_W-1:0]      x_i,
  input  nqj_sq_ctx_t         ctx_i,
  output logic                valid_o,
  output logic [R_W-1:0]      root_o,
  output nqj_sq_ctx_t         ctx_o
);

  logic [X_W-1:0] rem_q [0:SQ_STEPS-1];
  logic [X_W-1:0] res_q [0:SQ_STEPS-1];
  logic           v_q   [0:SQ_STEPS-1];
  nqj_sq_ctx_t    ctx_q [0:SQ_STEPS-1];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    localparam int unsigned SH = 2 * (SQ_STEPS - 1 - k);
    localparam logic [X_W-1:0] BITV = X_W'(1) << SH;
    logic [X_W-1:0] rem_in, res_in, rem_nx, res_nx;
    logic           v_in;
    nqj_sq_ctx_t    ctx_in;

    if (k == 0) begin : g_first
      assign rem_in = x_i;
      assign res_in = '0;
      assign v_in   = valid_i;
      assign ctx_in = ctx_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign v_in   = v_q[k-1];
      assign ctx_in = ctx_q[k-1];
    end

    always_comb begin
      if (rem_in >= res_in + BITV) begin
        rem_nx = rem_in - (res_in + BITV);
        res_nx = (res_in >> 1) + BITV;
      end else begin
        rem_nx = rem_in;
        res_nx = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_nx;
        res_q[k] <= res_nx;
        ctx_q[k] <= ctx_in;
      end
    end
  end

  assign valid_o = v_q[SQ_STEPS-1];
  assign root_o  = res_q[SQ_STEPS-1][R_W-1:0];
  assign ctx_o   = ctx_q[SQ_STEPS-1];

endmodule

[rtl/nqj_div.sv]
// Four-lane pipelined restoring divider with an overflow check stage.
// Depends on nqj_pkg for widths and the divider context type.
module nqj_div import nqj_pkg::*; #(
  parameter int unsigned IN_FRACTION_BITS = IN_FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  logic [D_W-1:0]                      d_i,
  input  logic [NUM_COLS-1:0][MAG_W-1:0]      mag_i,
  input  nqj_div_ctx_t                        ctx_i,
  output logic                                valid_o,
  output logic [D_W-1:0]                      d_o,
  output logic [NUM_COLS-1:0][OUT_WIDTH-1:0]  quo_o,
  output logic [NUM_COLS-1:0][D_W-1:0]        rem_o,
  output logic [NUM_COLS-1:0]                 ovf_o,
  output nqj_div_ctx_t                        ctx_o
);

  localparam int unsigned W   = OUT_WIDTH;
  localparam int unsigned NS  = IN_FRACTION_BITS + OUT_FRACTION_BITS + SQRT_EXTRA;
  localparam int unsigned NMW = MAG_W + NS;
  localparam int unsigned RW  = D_W + W;
  localparam int unsigned CW  = ((NMW > RW) ? NMW : RW) + 1;

  logic [NUM_COLS-1:0][RW-1:0] rem_q [0:W];
  logic [NUM_COLS-1:0][W-1:0]  quo_q [0:W];
  logic [NUM_COLS-1:0]         ovf_q [0:W];
  logic [D_W-1:0]              d_q   [0:W];
  logic                        v_q   [0:W];
  nqj_div_ctx_t                ctx_q [0:W];

  // Stage 0: scale the numerator and flag quotients that need more than W bits.
  logic [NUM_COLS-1:0][RW-1:0] rem0_d;
  logic [NUM_COLS-1:0]         ovf0_d;

  always_comb begin
    logic [CW-1:0] nm, dsh;
    nm  = '0;
    dsh = CW'(d_i) << W;
    for (int j = 0; j < NUM_COLS; j++) begin
      nm        = CW'(mag_i[j]) << NS;
      ovf0_d[j] = nm >= dsh;
      rem0_d[j] = nm[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= rem0_d;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf0_d;
      d_q[0]   <= d_i;
      ctx_q[0] <= ctx_i;
    end
  end

  // Stages 1..W: one quotient bit per stage, most significant first.
  for (genvar k = 1; k <= W; k++) begin : g_stage
    localparam int unsigned BI = W - k;
    logic [NUM_COLS-1:0][RW-1:0] rem_nx;
    logic [NUM_COLS-1:0][W-1:0]  quo_nx;

    always_comb begin
      logic [RW:0] dsh;
      dsh = (RW + 1)'(d_q[k-1]) << BI;
      for (int j = 0; j < NUM_COLS; j++) begin
        rem_nx[j] = rem_q[k-1][j];
        quo_nx[j] = quo_q[k-1][j];
        if ({1'b0, rem_q[k-1][j]} >= dsh) begin
          rem_nx[j]     = rem_q[k-1][j] - dsh[RW-1:0];
          quo_nx[j][BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_nx;
        quo_q[k] <= quo_nx;
        ovf_q[k] <= ovf_q[k-1];
        d_q[k]   <= d_q[k-1];
        ctx_q[k] <= ctx_q[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_COLS; j++) begin
      rem_o[j] = rem_q[W][j][D_W-1:0];
    end
  end

  assign valid_o = v_q[W];
  assign d_o     = d_q[W];
  assign quo_o   = quo_q[W];
  assign ovf_o   = ovf_q[W];
  assign ctx_o   = ctx_q[W];

endmodule

[rtl/normalized_quaternion_jacobian.sv]
// Top level of the normalized quaternion Jacobian block.
// Depends on nqj_pkg, nqj_sqrt and nqj_div.

// One request carries a quaternion of four signed Q2.14 components; the block answers
// with four row requests of the Jacobian of q/|q|, (|q|^2 I - q q^T) / |q|^3, each with
// four signed Q8.16 entries rounded to nearest (ties away from zero) and clipped to the
// output range, the row index, a last-row mark, a saturation flag and a zero-norm flag.
// A quaternion is taken in and issued into the pipeline one row per cycle, so the block
// delivers one row per cycle while the output is not stalled; a new quaternion can be
// taken as the one before issues its last row, and that issue stage sets the rate. Rows
// then pass two product and sum stages, a 32-stage square root, one stage for the
// denominator multiply, a divider of one overflow stage plus one stage per output bit,
// and an output register. A stalled output holds the whole pipeline, so nothing is lost
// or repeated, and a new quaternion is taken while rows are still in flight but not
// while a row waits at a stalled output.
module normalized_quaternion_jacobian import nqj_pkg::*; #(
  parameter int unsigned IN_FRACTION_BITS = IN_FRACTION_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  nqj_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output nqj_out_t out_req_o
);

  localparam int unsigned W = OUT_WIDTH;
  localparam logic [W:0] PMAX = (W + 1)'((1 << (W - 1)) - 1);
  localparam logic [W:0] NMAX = (W + 1)'(1) << (W - 1);

  // The whole pipeline moves whenever the output register is free or being emptied.
  logic adv;
  logic out_valid_q;
  nqj_out_t out_q;

  assign adv = !out_valid_q || out_ready_i;

  // Issue stage: hold the accepted quaternion and send one row per cycle while the pipeline advances.
  nqj_in_t    hold_q;
  logic [1:0] cnt_q;
  logic       busy_q;
  logic       take;

  assign in_ready_o = adv && (!busy_q || cnt_q == LAST_ROW);
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (take) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (adv && busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == LAST_ROW) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_q <= in_req_i;
    end
  end

  // Stage 1: all four squares and the products of the row component with each column.
  logic                             s1_v_q;
  logic [1:0]                       s1_row_q;
  logic [NUM_COLS-1:0][SQ_W-1:0]    s1_sq_q;
  logic [NUM_COLS-1:0][PR_W-1:0]    s1_pr_q;
  logic [NUM_COLS-1:0][SQ_W-1:0]    s1_sq_d;
  logic [NUM_COLS-1:0][PR_W-1:0]    s1_pr_d;

  always_comb begin
    logic signed [IN_W-1:0] qa, qr;
    logic signed [PR_W-1:0] p;
    qr = nqj_comp(hold_q, cnt_q);
    for (int j = 0; j < NUM_COLS; j++) begin
      qa         = nqj_comp(hold_q, 2'(j));
      p          = qa * qa;
      s1_sq_d[j] = p[SQ_W-1:0];
      p          = qr * qa;
      s1_pr_d[j] = p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_row_q <= cnt_q;
      s1_sq_q  <= s1_sq_d;
      s1_pr_q  <= s1_pr_d;
    end
  end

  // Stage 2: squared norm and the signed numerator row.
  logic        s2_v_q;
  nqj_sq_ctx_t s2_ctx_q;
  nqj_sq_ctx_t s2_ctx_d;

  always_comb begin
    logic [S_W-1:0]        s;
    logic signed [N_W-1:0] diag;
    s = '0;
    for (int j = 0; j < NUM_COLS; j++) begin
      s = s + S_W'(s1_sq_q[j]);
    end
    s2_ctx_d.row  = s1_row_q;
    s2_ctx_d.zero = (s == '0);
    s2_ctx_d.s    = s;
    for (int j = 0; j < NUM_COLS; j++) begin
      diag = (s1_row_q == 2'(j)) ? $signed(N_W'(s)) : '0;
      s2_ctx_d.n[j] = diag - N_W'($signed(s1_pr_q[j]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ctx_q <= s2_ctx_d;
    end
  end

  // Square root of the norm with 15 extra fraction bits.
  logic           sq_v;
  logic [R_W-1:0] sq_root;
  nqj_sq_ctx_t    sq_ctx;

  nqj_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s2_v_q),
    .x_i     (X_W'({s2_ctx_q.s, (2 * SQRT_EXTRA)'(0)})),
    .ctx_i   (s2_ctx_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .ctx_o   (sq_ctx)
  );

  // Denominator multiply and numerator magnitudes.
  logic                          dn_v_q;
  logic [D_W-1:0]                dn_d_q;
  logic [NUM_COLS-1:0][MAG_W-1:0] dn_mag_q;
  nqj_div_ctx_t                  dn_ctx_q;
  logic [NUM_COLS-1:0][MAG_W-1:0] dn_mag_d;
  logic [NUM_COLS-1:0]           dn_neg_d;
  logic [S_W+R_W-1:0]            dn_prod;

  assign dn_prod = sq_ctx.s * sq_root;

  always_comb begin
    logic [N_W-1:0] n;
    for (int j = 0; j < NUM_COLS; j++) begin
      n           = sq_ctx.n[j];
      dn_neg_d[j] = n[N_W-1];
      n           = dn_neg_d[j] ? (~n + N_W'(1)) : n;
      dn_mag_d[j] = n[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_v_q <= 1'b0;
    end else if (adv) begin
      dn_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dn_d_q        <= dn_prod[D_W-1:0];
      dn_mag_q      <= dn_mag_d;
      dn_ctx_q.row  <= sq_ctx.row;
      dn_ctx_q.zero <= sq_ctx.zero;
      dn_ctx_q.neg  <= dn_neg_d;
    end
  end

  // Divider lanes, one per column.
  logic                               dv_v;
  logic [D_W-1:0]                     dv_d;
  logic [NUM_COLS-1:0][OUT_WIDTH-1:0] dv_quo;
  logic [NUM_COLS-1:0][D_W-1:0]       dv_rem;
  logic [NUM_COLS-1:0]                dv_ovf;
  nqj_div_ctx_t                       dv_ctx;

  nqj_div #(
    .IN_FRACTION_BITS (IN_FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dn_v_q),
    .d_i     (dn_d_q),
    .mag_i   (dn_mag_q),
    .ctx_i   (dn_ctx_q),
    .valid_o (dv_v),
    .d_o     (dv_d),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .ovf_o   (dv_ovf),
    .ctx_o   (dv_ctx)
  );

  // Rounding, sign, saturation and the zero-norm override, then the output register.
  logic [NUM_COLS-1:0][W-1:0] ent_d;
  logic                       sat_d;
  nqj_out_t                   out_d;

  always_comb begin
    logic         rb, clip;
    logic [W:0]   val, lim;
    sat_d = 1'b0;
    for (int j = 0; j < NUM_COLS; j++) begin
      rb   = ((D_W + 1)'(dv_rem[j]) << 1) >= (D_W + 1)'(dv_d);
      val  = (W + 1)'(dv_quo[j]) + (W + 1)'(rb);
      lim  = dv_ctx.neg[j] ? NMAX : PMAX;
      clip = dv_ovf[j] || (val > lim);
      if (clip) begin
        val = lim;
      end
      if (dv_ctx.neg[j]) begin
        val = ~val + (W + 1)'(1);
      end
      ent_d[j] = val[W-1:0];
      sat_d    = sat_d | clip;
    end
    if (dv_ctx.zero) begin
      ent_d = '0;
      sat_d = 1'b0;
    end
    out_d.row_index  = dv_ctx.row;
    out_d.entry_col0 = ent_d[0];
    out_d.entry_col1 = ent_d[1];
    out_d.entry_col2 = ent_d[2];
    out_d.entry_col3 = ent_d[3];
    out_d.zero_norm  = dv_ctx.zero;
    out_d.saturated  = sat_d;
    out_d.last_row   = (dv_ctx.row == LAST_ROW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A zero quaternion must never report clipping and must give zero entries.
  a_zero_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.zero_norm |->
      !out_req_o.saturated && out_req_o.entry_col0 == '0 && out_req_o.entry_col1 == '0 &&
      out_req_o.entry_col2 == '0 && out_req_o.entry_col3 == '0)
    else $error("zero-norm row carries nonzero data");

  // The last-row mark follows the row index.
  a_last_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last_row == (out_req_o.row_index == LAST_ROW)))
    else $error("last_row does not match row_index");

  // An accepted quaternion starts issuing at row zero in the next cycle.
  a_issue_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> busy_q && cnt_q == '0)
    else $error("issue stage did not start a new quaternion");

  // Input is never taken while the pipeline is held.
  a_ready_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> adv)
    else $error("input ready while the pipeline is stalled");

endmodule
